>>> sv/cramp_pkg.sv
// Package for the color ramp interpolator: sizes, field structs and codes.
// Used by color_ramp_interpolator_unit; depends on nothing else.

package cramp_pkg;

    localparam int MAX_POINTS = 16;
    localparam int PIXELS     = 512;

    localparam int PT_IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W    = $clog2(MAX_POINTS + 1);

    localparam int POS_W   = 17;
    localparam int IDX_W   = 9;
    localparam int CH_W    = 8;
    localparam int COL_W   = 4 * CH_W;
    localparam int ENTRY_W = POS_W + COL_W;
    localparam int NUM_W   = POS_W + CH_W;      // c * d fits here
    localparam int REM_W   = NUM_W + 1;         // 2*num + d
    localparam int QB_W    = $clog2(CH_W);

    localparam logic [POS_W-1:0] POS_MAX = POS_W'((PIXELS - 1) * 256);
    localparam logic [COL_W-1:0] MAGENTA = 32'hFF00FFFF;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam logic RAMP_GRADIENT = 1'b0;
    localparam logic RAMP_DISCRETE = 1'b1;

    typedef struct packed {
        logic             mode;
        logic             first_point;
        logic [POS_W-1:0] position;
        logic [CH_W-1:0]  red_in;
        logic [CH_W-1:0]  green_in;
        logic [CH_W-1:0]  blue_in;
        logic [CH_W-1:0]  alpha_in;
        logic [IDX_W-1:0] pixel_index;
    } req_t;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic [CH_W-1:0] alpha_out;
        logic            index_error;
    } rsp_t;

endpackage

>>> sv/color_ramp_interpolator_unit.sv
// Color ramp interpolator: control-point table plus gradient/discrete pixel read.
// Depends on cramp_pkg (sizes, request/response structs, codes).

// A load request gives no response; busy stays low.
// A gradient read holds busy high while a sequencer walks the point table
// through a memory with separate write and read ports and registered read
// data, one point per ST_RD/ST_CMP pass. Interpolation runs the four channels
// one after another through one shared 8x17 multiplier (ST_MULA, ST_MULB)
// and a restoring divider that retires one quotient bit per cycle (ST_DIV).
// A discrete read in range holds busy high through ST_RD and ST_CMP; a
// read of an empty table or a discrete index out of range never raises busy.
// rsp_valid pulses for one cycle with rsp, in the first cycle with busy low
// after the read (the cycle right after the request when busy never rises);
// the response cannot be held off, so capture it then.
module color_ramp_interpolator_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cramp_pkg::req_t      req,
    output logic                 rsp_valid,
    output cramp_pkg::rsp_t      rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RD   = 6'b000010,
        ST_CMP  = 6'b000100,
        ST_MULA = 6'b001000,
        ST_MULB = 6'b010000,
        ST_DIV  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [cramp_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                           ramp_mode_reg, ramp_mode_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    logic [cramp_pkg::PT_IDX_W-1:0] pt_reg, pt_next;
    logic                           disc_reg, disc_next;

    cramp_pkg::rsp_t                rsp_reg, rsp_next;
    logic [cramp_pkg::POS_W-1:0]    x_reg, x_next;
    logic [cramp_pkg::POS_W-1:0]    prev_pos_reg, prev_pos_next;
    logic [cramp_pkg::COL_W-1:0]    prev_col_reg, prev_col_next;
    logic [cramp_pkg::COL_W-1:0]    c1_reg, c1_next;
    logic [cramp_pkg::POS_W-1:0]    d_reg, d_next;
    logic [cramp_pkg::POS_W-1:0]    t_reg, t_next;
    logic [1:0]                     ch_reg, ch_next;
    logic [cramp_pkg::NUM_W-1:0]    acc_reg, acc_next;
    logic [cramp_pkg::REM_W-1:0]    rem_reg, rem_next;
    logic [cramp_pkg::QB_W-1:0]     qb_reg, qb_next;
    logic [cramp_pkg::CH_W-1:0]     q_reg, q_next;
    logic [cramp_pkg::COL_W-1:0]    col_reg, col_next;

    logic [cramp_pkg::ENTRY_W-1:0]  point_mem [cramp_pkg::MAX_POINTS];
    logic [cramp_pkg::ENTRY_W-1:0]  rd_data_reg;

    logic                           wr_en;
    logic [cramp_pkg::PT_IDX_W-1:0] wr_addr;
    logic [cramp_pkg::ENTRY_W-1:0]  wr_data;

    logic                           accept;
    logic [cramp_pkg::CNT_W-1:0]    base_cnt;
    logic [cramp_pkg::POS_W-1:0]    pos_sat;
    logic [cramp_pkg::POS_W-1:0]    cur_pos;
    logic [cramp_pkg::COL_W-1:0]    cur_col;
    logic                           is_last;
    logic [cramp_pkg::CH_W-1:0]     mul_a;
    logic [cramp_pkg::POS_W-1:0]    mul_b;
    logic [cramp_pkg::NUM_W-1:0]    prod;
    logic [cramp_pkg::NUM_W-1:0]    acc_sum;
    logic [cramp_pkg::REM_W-1:0]    div_shift;
    logic                           q_bit;

    function automatic logic [cramp_pkg::CH_W-1:0] chan_sel(
        input logic [cramp_pkg::COL_W-1:0] c,
        input logic [1:0]                  k
    );
        logic [cramp_pkg::CH_W-1:0] v;
        unique case (k)
            2'd0:    v = c[31:24];
            2'd1:    v = c[23:16];
            2'd2:    v = c[15:8];
            default: v = c[7:0];
        endcase
        return v;
    endfunction

    function automatic cramp_pkg::rsp_t make_rsp(
        input logic [cramp_pkg::COL_W-1:0] c,
        input logic                        err
    );
        cramp_pkg::rsp_t r;
        r.red_out     = c[31:24];
        r.green_out   = c[23:16];
        r.blue_out    = c[15:8];
        r.alpha_out   = c[7:0];
        r.index_error = err;
        return r;
    endfunction

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign base_cnt = req.first_point ? '0 : cnt_reg;
    assign pos_sat  = (req.position > cramp_pkg::POS_MAX) ? cramp_pkg::POS_MAX : req.position;
    assign wr_en    = accept && (req.mode == cramp_pkg::MODE_LOAD)
                      && (base_cnt < cramp_pkg::CNT_W'(cramp_pkg::MAX_POINTS));
    assign wr_addr  = base_cnt[cramp_pkg::PT_IDX_W-1:0];
    assign wr_data  = {pos_sat, req.red_in, req.green_in, req.blue_in, req.alpha_in};

    assign cur_pos = rd_data_reg[cramp_pkg::ENTRY_W-1:cramp_pkg::COL_W];
    assign cur_col = rd_data_reg[cramp_pkg::COL_W-1:0];
    assign is_last = (cramp_pkg::CNT_W'(pt_reg) + cramp_pkg::CNT_W'(1)) == cnt_reg;

    // shared multiplier: c0*(d-t) first, then c1*t
    assign mul_a   = (state_reg == ST_MULA) ? chan_sel(prev_col_reg, ch_reg)
                                            : chan_sel(c1_reg, ch_reg);
    assign mul_b   = (state_reg == ST_MULA) ? (d_reg - t_reg) : t_reg;
    assign prod    = cramp_pkg::NUM_W'(mul_a) * cramp_pkg::NUM_W'(mul_b);
    assign acc_sum = acc_reg + prod;

    assign div_shift = {cramp_pkg::REM_W'({d_reg, 1'b0})} << qb_reg;
    assign q_bit     = (rem_reg >= div_shift);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            point_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= point_mem[pt_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ramp_mode_next = ramp_mode_reg;
        rsp_valid_next = 1'b0;
        pt_next        = pt_reg;
        disc_next      = disc_reg;
        rsp_next       = rsp_reg;
        x_next         = x_reg;
        prev_pos_next  = prev_pos_reg;
        prev_col_next  = prev_col_reg;
        c1_next        = c1_reg;
        d_next         = d_reg;
        t_next         = t_reg;
        ch_next        = ch_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        qb_next        = qb_reg;
        q_next         = q_reg;
        col_next       = col_reg;

        if (cfg_valid && cfg_ready)
        begin
            ramp_mode_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.mode == cramp_pkg::MODE_LOAD)
                    begin
                        if (wr_en)
                        begin
                            cnt_next = base_cnt + cramp_pkg::CNT_W'(1);
                        end
                        else
                        begin
                            cnt_next = base_cnt;
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        rsp_next       = make_rsp(cramp_pkg::MAGENTA, 1'b0);
                        rsp_valid_next = 1'b1;
                    end
                    else if (ramp_mode_reg == cramp_pkg::RAMP_DISCRETE)
                    begin
                        if (cramp_pkg::IDX_W'(cnt_reg) > req.pixel_index)
                        begin
                            pt_next    = req.pixel_index[cramp_pkg::PT_IDX_W-1:0];
                            disc_next  = 1'b1;
                            state_next = ST_RD;
                        end
                        else
                        begin
                            rsp_next       = make_rsp('0, 1'b1);
                            rsp_valid_next = 1'b1;
                        end
                    end
                    else
                    begin
                        x_next     = {req.pixel_index, 8'd0};
                        pt_next    = '0;
                        disc_next  = 1'b0;
                        state_next = ST_RD;
                    end
                end
            end

            ST_RD:
            begin
                state_next = ST_CMP;
            end

            ST_CMP:
            begin
                if (disc_reg)
                begin
                    rsp_next       = make_rsp(cur_col, 1'b0);
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (x_reg <= cur_pos)
                begin
                    if (pt_reg == '0)
                    begin
                        rsp_next       = make_rsp(cur_col, 1'b0);
                        rsp_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        d_next     = cur_pos - prev_pos_reg;
                        t_next     = x_reg - prev_pos_reg;
                        c1_next    = cur_col;
                        ch_next    = '0;
                        state_next = ST_MULA;
                    end
                end
                else if (is_last)
                begin
                    rsp_next       = make_rsp(cur_col, 1'b0);
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    prev_pos_next = cur_pos;
                    prev_col_next = cur_col;
                    pt_next       = pt_reg + cramp_pkg::PT_IDX_W'(1);
                    state_next    = ST_RD;
                end
            end

            ST_MULA:
            begin
                acc_next   = prod;
                state_next = ST_MULB;
            end

            ST_MULB:
            begin
                // round half up: (2*num + d) / (2*d)
                rem_next   = {acc_sum, 1'b0} + cramp_pkg::REM_W'(d_reg);
                qb_next    = cramp_pkg::QB_W'(cramp_pkg::CH_W - 1);
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                if (q_bit)
                begin
                    rem_next = rem_reg - div_shift;
                end
                q_next = {q_reg[cramp_pkg::CH_W-2:0], q_bit};
                if (qb_reg == '0)
                begin
                    col_next = {col_reg[cramp_pkg::COL_W-cramp_pkg::CH_W-1:0], q_next};
                    if (ch_reg == 2'd3)
                    begin
                        rsp_next       = make_rsp(col_next, 1'b0);
                        rsp_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = ST_MULA;
                    end
                end
                else
                begin
                    qb_next = qb_reg - cramp_pkg::QB_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ramp_mode_reg <= cramp_pkg::RAMP_GRADIENT;
            rsp_valid_reg <= 1'b0;
            pt_reg        <= '0;
            disc_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ramp_mode_reg <= ramp_mode_next;
            rsp_valid_reg <= rsp_valid_next;
            pt_reg        <= pt_next;
            disc_reg      <= disc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg      <= rsp_next;
        x_reg        <= x_next;
        prev_pos_reg <= prev_pos_next;
        prev_col_reg <= prev_col_next;
        c1_reg       <= c1_next;
        d_reg        <= d_next;
        t_reg        <= t_next;
        ch_reg       <= ch_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        qb_reg       <= qb_next;
        q_reg        <= q_next;
        col_reg      <= col_next;
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= cramp_pkg::CNT_W'(cramp_pkg::MAX_POINTS))
        else $error("point count above table size");

    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ($past(busy) || $past(start && req.mode == cramp_pkg::MODE_READ)))
        else $error("response without a read request");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.index_error) |->
            (rsp.red_out == '0 && rsp.green_out == '0 && rsp.blue_out == '0
             && rsp.alpha_out == '0 && ramp_mode_reg == cramp_pkg::RAMP_DISCRETE))
        else $error("index error with nonzero color or in gradient mode");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && qb_reg == '0) |=>
            (rem_reg < cramp_pkg::REM_W'({d_reg, 1'b0})))
        else $error("divider remainder not below divisor");

    a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.mode == cramp_pkg::MODE_LOAD) |=> (!busy && !rsp_valid))
        else $error("load request started a read sequence");
`endif

endmodule

>>> verif/tb.sv
// Testbench for color_ramp_interpolator_unit: directed and random load/read requests,
// checked against a predictor of the control-point table held in a small scoreboard.
// Depends on cramp_pkg and color_ramp_interpolator_unit.

module tb;
    import cramp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_ITEMS   = 1330;
    localparam int PHASES         = 6;

    class ramp_scoreboard;
        logic [POS_W-1:0] pos_tab [MAX_POINTS];
        logic [COL_W-1:0] col_tab [MAX_POINTS];
        int unsigned      pt_count;
        logic             ramp_mode;
        rsp_t             pixel_q [$];
        int               errors;

        function new();
            pt_count  = 0;
            ramp_mode = RAMP_GRADIENT;
            errors    = 0;
        endfunction

        function void set_mode(logic m);
            ramp_mode = m;
        endfunction

        function int pending();
            return pixel_q.size();
        endfunction

        function rsp_t colour_rsp(logic [COL_W-1:0] c, logic err);
            rsp_t r;
            r.red_out     = c[COL_W-1 -: CH_W];
            r.green_out   = c[COL_W-1-CH_W -: CH_W];
            r.blue_out    = c[COL_W-1-2*CH_W -: CH_W];
            r.alpha_out   = c[CH_W-1:0];
            r.index_error = err;
            return r;
        endfunction

        function rsp_t predict_pixel(logic [IDX_W-1:0] idx);
            longint           x, p0, d, t, num, c0, c1;
            int unsigned      i;
            int               k;
            logic [COL_W-1:0] mix;
            if (pt_count == 0)
                return colour_rsp(MAGENTA, 1'b0);
            if (ramp_mode == RAMP_DISCRETE)
            begin
                if (idx < pt_count)
                    return colour_rsp(col_tab[idx], 1'b0);
                return colour_rsp('0, 1'b1);
            end
            x = longint'(idx) * 256;
            i = 0;
            // table is searched in load order, never sorted
            while (i < pt_count && x > longint'(pos_tab[i]))
                i++;
            if (i == 0)
                return colour_rsp(col_tab[0], 1'b0);
            if (i == pt_count)
                return colour_rsp(col_tab[pt_count-1], 1'b0);
            p0 = pos_tab[i-1];
            d  = longint'(pos_tab[i]) - p0;
            t  = x - p0;
            for (k = 0; k < 4; k++)
            begin
                c0  = col_tab[i-1][COL_W-1-CH_W*k -: CH_W];
                c1  = col_tab[i][COL_W-1-CH_W*k -: CH_W];
                num = c0 * (d - t) + c1 * t;
                // round half up
                mix[COL_W-1-CH_W*k -: CH_W] = CH_W'((2 * num + d) / (2 * d));
            end
            return colour_rsp(mix, 1'b0);
        endfunction

        function void note_request(req_t r);
            logic [POS_W-1:0] p;
            if (r.mode == MODE_LOAD)
            begin
                if (r.first_point)
                    pt_count = 0;
                p = (r.position > POS_MAX) ? POS_MAX : r.position;
                if (pt_count < MAX_POINTS)
                begin
                    pos_tab[pt_count] = p;
                    col_tab[pt_count] = {r.red_in, r.green_in, r.blue_in, r.alpha_in};
                    pt_count++;
                end
            end
            else
                pixel_q.push_back(predict_pixel(r.pixel_index));
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        task check_result(rsp_t got);
            rsp_t want;
            if (pixel_q.size() == 0)
            begin
                report_mismatch($sformatf("pixel with no read pending: %h", got));
                return;
            end
            want = pixel_q.pop_front();
            if (got.red_out !== want.red_out)
                report_mismatch($sformatf("red_out %h, want %h", got.red_out, want.red_out));
            if (got.green_out !== want.green_out)
                report_mismatch($sformatf("green_out %h, want %h",
                                          got.green_out, want.green_out));
            if (got.blue_out !== want.blue_out)
                report_mismatch($sformatf("blue_out %h, want %h", got.blue_out, want.blue_out));
            if (got.alpha_out !== want.alpha_out)
                report_mismatch($sformatf("alpha_out %h, want %h",
                                          got.alpha_out, want.alpha_out));
            if (got.index_error !== want.index_error)
                report_mismatch($sformatf("index_error %b, want %b",
                                          got.index_error, want.index_error));
        endtask
    endclass

    logic clk       = 1'b0;
    logic rst_n;
    logic start     = 1'b0;
    logic busy;
    req_t req       = '0;
    logic rsp_valid;
    rsp_t rsp;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data  = 1'b0;

    ramp_scoreboard sb;
    int  stall_cycles = 0;
    int  burst_left   = 0;
    bit  pacing_on    = 1'b0;

    color_ramp_interpolator_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid)
                sb.check_result(rsp);
            if (start && !busy)
                sb.note_request(req);
            if (cfg_valid && cfg_ready)
                sb.set_mode(cfg_data);
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || rsp_valid || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL color_ramp_interpolator_unit");
            $finish;
        end
    end

    task automatic idle(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // bursts of requests with random gaps between them
    task automatic pace();
        if (!pacing_on)
            return;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            idle($urandom_range(1, 12));
            burst_left = $urandom_range(0, 15);
        end
    endtask

    task automatic send(req_t r);
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pace();
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(logic m);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic req_t noise_req();
        logic [63:0] raw;
        req_t        r;
        raw = {$urandom, $urandom};
        r   = raw[$bits(req_t)-1:0];
        return r;
    endfunction

    function automatic req_t load_req(logic first, logic [POS_W-1:0] pos);
        req_t r;
        r             = noise_req();
        r.mode        = MODE_LOAD;
        r.first_point = first;
        r.position    = pos;
        if ($urandom_range(0, 7) == 0)
            {r.red_in, r.green_in, r.blue_in, r.alpha_in} = $urandom_range(0, 1) ? '1 : '0;
        return r;
    endfunction

    function automatic req_t read_req(logic [IDX_W-1:0] idx);
        req_t r;
        r             = noise_req();
        r.mode        = MODE_READ;
        r.pixel_index = idx;
        return r;
    endfunction

    task automatic send_point(logic first, logic [POS_W-1:0] pos, logic [COL_W-1:0] col);
        req_t r;
        r = load_req(first, pos);
        {r.red_in, r.green_in, r.blue_in, r.alpha_in} = col;
        send(r);
    endtask

    initial
    begin
        int m, per_phase, sent, n, j, style, reads, p, pos_step;
        logic [IDX_W-1:0] idx;

        sb    = new();
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // empty table in both ramp modes
        write_mode(RAMP_DISCRETE);
        send(read_req('0));
        drain();
        write_mode(RAMP_GRADIENT);
        send(read_req('1));

        // black at zero to white at the saturated end
        send_point(1'b1, '0, '0);
        send_point(1'b0, '1, '1);
        send(read_req(9'd0));
        send(read_req(9'd511));
        send(read_req(9'd256));
        send(read_req(9'd1));

        // restart, then one point: before it and past it
        send_point(1'b1, 17'd1000, 32'h12345678);
        send(read_req(9'd0));
        send(read_req(9'd3));
        send(read_req(9'd4));

        // unsorted table
        send_point(1'b0, 17'd2000, 32'hFF8000C0);
        send_point(1'b0, 17'd1500, 32'h00FFFF01);
        send(read_req(9'd6));
        send(read_req(9'd7));
        send(read_req(9'd8));

        // discrete: in range, last point, out of range
        drain();
        write_mode(RAMP_DISCRETE);
        send(read_req(9'd0));
        send(read_req(9'd2));
        send(read_req(9'd3));
        send(read_req(9'd511));

        per_phase = RANDOM_ITEMS / PHASES;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            m = (ph % 2 == 0) ? RAMP_GRADIENT : RAMP_DISCRETE;
            write_mode(m[0]);
            pacing_on  = (ph != 2);
            burst_left = 0;
            sent = 0;
            while (sent < per_phase)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    send(noise_req());
                    sent++;
                end
                else
                begin
                    // restart the table, fill it (sometimes past capacity), then read
                    n     = $urandom_range(1, 20);
                    style = $urandom_range(0, 2);
                    p     = $urandom_range(0, 3000);
                    for (j = 0; j < n; j++)
                    begin
                        if (style == 1)
                            p = $urandom_range(0, 131071);
                        send(load_req(j == 0, p[POS_W-1:0]));
                        if (j < MAX_POINTS)
                            sent++;
                        pos_step = (style == 2) ? $urandom_range(0, 600)
                                                : $urandom_range(0, 16000);
                        p = p + pos_step;
                        if (p > 131071)
                            p = 131071;
                    end
                    reads = $urandom_range(1, 10);
                    for (j = 0; j < reads; j++)
                    begin
                        if (m == RAMP_DISCRETE && $urandom_range(0, 3) != 0)
                            idx = $urandom_range(0, 20);
                        else if ($urandom_range(0, 6) == 0)
                            idx = $urandom_range(0, 1) ? '1 : '0;
                        else
                            idx = $urandom_range(0, 511);
                        send(read_req(idx));
                        sent++;
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    drain();
            end
        end

        drain();
        if (sb.errors == 0)
            $display("PASS color_ramp_interpolator_unit");
        else
            $display("FAIL color_ramp_interpolator_unit");
        $finish;
    end

endmodule

>>> sim.f
sv/cramp_pkg.sv
sv/color_ramp_interpolator_unit.sv
verif/tb.sv
